### sv/cwfe_pkg.sv
// ----------------------------------------------------------------------------
// cwfe_pkg
// Shared types and constants of the CRC-32 word frame engine: opcode codes,
// the decoded command that crosses the internal queue and the fold columns.
// ----------------------------------------------------------------------------
package cwfe_pkg;

  localparam int unsigned CRC_W  = 32;
  localparam int unsigned OP_W   = 2;

  localparam logic [CRC_W-1:0] CRC_POLY = 32'h04C1_1DB7;
  localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

  typedef logic [OP_W-1:0]  op_t;
  typedef logic [CRC_W-1:0] crc_t;

  localparam op_t OP_FEED  = 2'd0;
  localparam op_t OP_START = 2'd1;
  localparam op_t OP_CHECK = 2'd2;
  localparam op_t OP_NOP   = 2'd3;

  // decoded item handed from the front to the back
  typedef struct packed {
    logic restart;
    logic fold;
    logic check;
    crc_t word;
  } cmd_t;

  // x^(32+idx) mod poly: the contribution of bit idx of (crc ^ word)
  function automatic crc_t crc_col(input int unsigned idx);
    crc_t v;
    v = crc_t'(1);
    for (int unsigned n = 0; n < idx + CRC_W; n++) begin
      v = v[CRC_W-1] ? ((v << 1) ^ CRC_POLY) : (v << 1);
    end
    return v;
  endfunction

endpackage

### sv/cwfe_if.sv
// ----------------------------------------------------------------------------
// cwfe_if
// Valid/ready channels of the CRC-32 word frame engine: the item input
// channel and the result channel.
// ----------------------------------------------------------------------------
interface cwfe_in_if;
  logic             valid;
  logic             ready;
  cwfe_pkg::op_t    opcode;
  cwfe_pkg::crc_t   data_word;

  modport source (output valid, output opcode, output data_word, input ready);
  modport sink   (input valid, input opcode, input data_word, output ready);
endinterface

interface cwfe_out_if;
  logic             valid;
  logic             ready;
  cwfe_pkg::crc_t   crc_value;
  logic             match_valid;
  logic             crc_match;

  modport source (output valid, output crc_value, output match_valid,
                  output crc_match, input ready);
  modport sink   (input valid, input crc_value, input match_valid,
                  input crc_match, output ready);
endinterface

### sv/cwfe_front.sv
// ----------------------------------------------------------------------------
// cwfe_front
// Accepts items from the input channel and decodes the opcode into a
// command for the queue.
// ----------------------------------------------------------------------------
module cwfe_front (
  cwfe_in_if.sink        in_ch,
  output logic           push,
  output cwfe_pkg::cmd_t push_cmd,
  input  logic           q_ready
);

  cwfe_pkg::cmd_t cmd;

  always_comb begin
    cmd         = '0;
    cmd.word    = in_ch.data_word;
    case (in_ch.opcode)
      cwfe_pkg::OP_FEED: begin
        cmd.fold = 1'b1;
      end
      cwfe_pkg::OP_START: begin
        cmd.fold    = 1'b1;
        cmd.restart = 1'b1;
      end
      cwfe_pkg::OP_CHECK: begin
        cmd.check = 1'b1;
      end
      default: begin
        // unused opcode passes as a no-op
        cmd.fold = 1'b0;
      end
    endcase
  end

  assign in_ch.ready = q_ready;
  assign push        = in_ch.valid && q_ready;
  assign push_cmd    = cmd;

endmodule

### sv/cwfe_queue.sv
// ----------------------------------------------------------------------------
// cwfe_queue
// Small first-in first-out queue of decoded commands between the front and
// the back.
// ----------------------------------------------------------------------------
module cwfe_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cwfe_pkg::cmd_t push_cmd,
  output logic           q_ready,
  input  logic           pop,
  output cwfe_pkg::cmd_t pop_cmd,
  output logic           q_valid
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cwfe_pkg::cmd_t   slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign q_ready = (count_r != CNT_W'(DEPTH));
  assign q_valid = (count_r != '0);
  assign pop_cmd = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> count_r != CNT_W'(DEPTH))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("queue pop while empty");

endmodule

### sv/cwfe_back.sv
// ----------------------------------------------------------------------------
// cwfe_back
// Holds the running CRC, folds one word per cycle unless out_ch stalls, via a
// constant XOR network, compares on check items and registers the result item.
// ----------------------------------------------------------------------------
module cwfe_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  cwfe_pkg::cmd_t pop_cmd,
  output logic           pop,
  cwfe_out_if.source     out_ch
);

  localparam int unsigned W = cwfe_pkg::CRC_W;

  cwfe_pkg::crc_t crc_r, crc_nxt;
  logic           out_valid_r, out_valid_nxt;
  cwfe_pkg::crc_t out_crc_r;
  logic           out_mvalid_r;
  logic           out_match_r;

  cwfe_pkg::crc_t fold_in;
  cwfe_pkg::crc_t fold_out;
  cwfe_pkg::crc_t term [W];
  cwfe_pkg::crc_t res_crc;

  assign fold_in = (pop_cmd.restart ? cwfe_pkg::CRC_INIT : crc_r) ^ pop_cmd.word;

  for (genvar i = 0; i < W; i++) begin : g_col
    localparam cwfe_pkg::crc_t COL = cwfe_pkg::crc_col(i);
    assign term[i] = fold_in[i] ? COL : '0;
  end

  always_comb begin
    fold_out = '0;
    for (int unsigned i = 0; i < W; i++) begin
      fold_out = fold_out ^ term[i];
    end
  end

  assign pop = q_valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    crc_nxt = crc_r;
    res_crc = crc_r;
    if (pop) begin
      if (pop_cmd.fold) begin
        crc_nxt = fold_out;
        res_crc = fold_out;
      end else if (pop_cmd.check) begin
        crc_nxt = cwfe_pkg::CRC_INIT;
      end
    end
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= cwfe_pkg::CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_crc_r    <= res_crc;
      out_mvalid_r <= pop_cmd.check;
      out_match_r  <= pop_cmd.check && (pop_cmd.word == crc_r);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.crc_value   = out_crc_r;
  assign out_ch.match_valid = out_mvalid_r;
  assign out_ch.crc_match   = out_match_r;

  a_check_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && pop_cmd.check) |=> crc_r == cwfe_pkg::CRC_INIT)
    else $error("crc not restarted after check item");

  a_match_needs_check: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_match_r) |-> out_mvalid_r)
    else $error("match flagged on a non-check item");

  a_nop_keeps_crc: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !pop_cmd.fold && !pop_cmd.check) |=> $stable(crc_r))
    else $error("crc changed on a no-op item");

endmodule

### sv/crc32_word_frame_engine.sv
// ----------------------------------------------------------------------------
// crc32_word_frame_engine
// CRC-32 (poly 04C11DB7, init all ones, no final inversion, msb first) over
// frames of 32-bit words, with in-line check of a received CRC word.
//
// in_ch carries opcode and data_word: feed continues the frame, start
// restarts the crc before folding the word, check compares data_word with
// the frame crc and ends the frame; the unused code is a no-op. out_ch
// returns one item per input item, in order: crc_value, match_valid and
// crc_match.
// An accepted item lands in the command queue, and the fold stage then
// loads its result into the output register that drives out_ch.valid.
// Throughput is one item per cycle while out_ch is ready; the whole 32-bit
// fold is one XOR network on the running crc register, so consecutive
// items chain without bubbles.
// When out_ch stalls the result holds in the output register, the queue
// fills, and in_ch.ready falls once QUEUE_DEPTH items wait.
// After reset the queue is empty, no result is pending and the running crc
// is all ones.
// ----------------------------------------------------------------------------
module crc32_word_frame_engine #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  cwfe_in_if.sink     in_ch,
  cwfe_out_if.source  out_ch
);

  logic           push;
  logic           pop;
  logic           q_ready;
  logic           q_valid;
  cwfe_pkg::cmd_t push_cmd;
  cwfe_pkg::cmd_t pop_cmd;

  cwfe_front u_front (
    .in_ch    (in_ch),
    .push     (push),
    .push_cmd (push_cmd),
    .q_ready  (q_ready)
  );

  cwfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .q_ready  (q_ready),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .q_valid  (q_valid)
  );

  cwfe_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .pop_cmd (pop_cmd),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule
